@@ sv/assert_macros.svh @@
// assertion helpers shared by the tag span grouper modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent holds, consequent must hold in the same cycle
`define TSG_ASSERT_SAME(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// antecedent holds, consequent must hold in the following cycle
`define TSG_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/tsg_pkg.sv @@
// ----------------------------------------------------------------------------
// tsg_pkg
// Types and constants shared by the tag span grouper modules.
// ----------------------------------------------------------------------------
package tsg_pkg;

   localparam int unsigned ADDR_W      = 20;
   localparam int unsigned LEN_W       = 21;
   localparam int unsigned POLL_W      = 24;
   localparam int unsigned GRP_W       = 16;
   localparam int unsigned CSR_IDX_W   = 2;
   localparam int unsigned CSR_DATA_W  = 16;

   // poll period used when no tag of a group gives one
   localparam logic [POLL_W-1:0] DEFAULT_POLL_MS = 24'd1000;

   // register width code saturates here (16-bit registers)
   localparam logic [2:0] MAX_REG_W_LOG2 = 3'd4;

   // record kinds
   localparam logic REC_ASSIGN = 1'b0;
   localparam logic REC_GROUP  = 1'b1;

   // csr register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_GROUP_BYTES     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GROUPING_ENABLED    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REGISTER_WIDTH_LOG2 = 2'd2;

   // csr reset values
   localparam logic [15:0] RST_MAX_GROUP_BYTES     = 16'd1000;
   localparam logic        RST_GROUPING_ENABLED    = 1'b1;
   localparam logic [2:0]  RST_REGISTER_WIDTH_LOG2 = 3'd4;

   typedef struct packed {
      logic [ADDR_W-1:0] tag_start_bit;
      logic [ADDR_W-1:0] tag_end_bit;
      logic [POLL_W-1:0] tag_poll_period;
      logic              final_tag;
   } req_type;

   typedef struct packed {
      logic              record_kind;
      logic [GRP_W-1:0]  group_number;
      logic [ADDR_W-1:0] span_start_bit;
      logic [ADDR_W-1:0] span_end_bit;
      logic [LEN_W-1:0]  span_length_bits;
      logic [POLL_W-1:0] group_poll_period;
      logic [ADDR_W-1:0] first_register;
      logic [LEN_W-1:0]  register_count;
      logic              last_record;
   } rsp_type;

   typedef struct packed {
      logic [15:0] max_group_bytes;
      logic        grouping_enabled;
      logic [2:0]  register_width_log2;
   } cfg_type;

   // group snapshot before the span and register fields are worked out
   typedef struct packed {
      logic              kind;
      logic              last;
      logic [GRP_W-1:0]  number;
      logic [ADDR_W-1:0] start_bit;
      logic [ADDR_W-1:0] end_bit;
      logic [POLL_W-1:0] poll;
   } raw_rec_type;

   // one to three records caused by one tag, packed from slot 0
   typedef struct packed {
      logic        valid;
      logic [1:0]  count;
      raw_rec_type rec0;
      raw_rec_type rec1;
      raw_rec_type rec2;
   } push_type;

endpackage

@@ sv/tsg_csr.sv @@
// ----------------------------------------------------------------------------
// tsg_csr
// Configuration registers of the tag span grouper, written by index.
// ----------------------------------------------------------------------------
module tsg_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [tsg_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tsg_pkg::CSR_DATA_W-1:0] csr_wdata,
   output tsg_pkg::cfg_type             cfg
);
   import tsg_pkg::*;

   cfg_type cfg_ff;

   // writes are taken in every cycle outside reset
   assign csr_ready = !reset;
   assign cfg       = cfg_ff;

   // register writes, unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_group_bytes     <= RST_MAX_GROUP_BYTES;
         cfg_ff.grouping_enabled    <= RST_GROUPING_ENABLED;
         cfg_ff.register_width_log2 <= RST_REGISTER_WIDTH_LOG2;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_MAX_GROUP_BYTES: begin
               cfg_ff.max_group_bytes <= csr_wdata;
            end
            CSR_GROUPING_ENABLED: begin
               cfg_ff.grouping_enabled <= csr_wdata[0];
            end
            CSR_REGISTER_WIDTH_LOG2: begin
               cfg_ff.register_width_log2 <= csr_wdata[2:0];
            end
            default: begin
            end
         endcase
      end
   end

endmodule

@@ sv/tsg_merge.sv @@
// ----------------------------------------------------------------------------
// tsg_merge
// Input register and open-group state; merges one tag per cycle while the
// result buffer has room and builds the records it causes.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tsg_merge (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  tsg_pkg::req_type req_data,
   input  tsg_pkg::cfg_type cfg,
   input  logic             buf_room,
   output tsg_pkg::push_type push
);
   import tsg_pkg::*;

   logic              in_vld_ff;
   req_type           in_ff;
   logic              load;

   logic              open_ff;
   logic [ADDR_W-1:0] start_ff;
   logic [ADDR_W-1:0] end_ff;
   logic [POLL_W-1:0] poll_ff;
   logic [GRP_W-1:0]  counter_ff;

   logic [ADDR_W-1:0] span_diff;
   logic [ADDR_W-1:0] limit;
   logic              reach;
   logic              close_first;
   logic              opens;
   logic              poll_given;
   logic [ADDR_W-1:0] start_in;
   logic [ADDR_W-1:0] end_in;
   logic [POLL_W-1:0] poll_in;
   logic [GRP_W-1:0]  counter_in;
   raw_rec_type       rec_close;
   raw_rec_type       rec_assign;
   raw_rec_type       rec_final;

   // no transaction is taken while in reset
   assign load      = in_vld_ff && buf_room;
   assign req_ready = !reset && (!in_vld_ff || buf_room);

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_ready) begin
         in_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ff <= req_data;
      end
   end

   // span limit test against the open group
   assign limit       = {1'b0, cfg.max_group_bytes, 3'b000};
   assign span_diff   = in_ff.tag_end_bit - start_ff;
   assign reach       = (in_ff.tag_end_bit >= start_ff) && (span_diff >= limit);
   assign close_first = open_ff && (!cfg.grouping_enabled || reach);
   assign opens       = !open_ff || close_first;
   assign poll_given  = in_ff.tag_poll_period != '0;

   // group values after the tag is merged
   always_comb begin
      if (opens) begin
         counter_in = counter_ff + 1'b1;
         start_in   = in_ff.tag_start_bit;
         end_in     = in_ff.tag_end_bit;
         poll_in    = poll_given ? in_ff.tag_poll_period : DEFAULT_POLL_MS;
      end else begin
         counter_in = counter_ff;
         start_in   = start_ff;
         end_in     = (in_ff.tag_end_bit > end_ff) ? in_ff.tag_end_bit : end_ff;
         poll_in    = (poll_given && (in_ff.tag_poll_period < poll_ff)) ?
                      in_ff.tag_poll_period : poll_ff;
      end
   end

   // records in delivery order
   always_comb begin
      rec_close.kind      = REC_GROUP;
      rec_close.last      = 1'b0;
      rec_close.number    = counter_ff;
      rec_close.start_bit = start_ff;
      rec_close.end_bit   = end_ff;
      rec_close.poll      = poll_ff;

      rec_assign.kind      = REC_ASSIGN;
      rec_assign.last      = 1'b0;
      rec_assign.number    = counter_in;
      rec_assign.start_bit = start_in;
      rec_assign.end_bit   = end_in;
      rec_assign.poll      = poll_in;

      rec_final      = rec_assign;
      rec_final.kind = REC_GROUP;
      rec_final.last = 1'b1;

      push.valid = load;
      push.count = 2'd1 + {1'b0, close_first} + {1'b0, in_ff.final_tag};
      push.rec0  = close_first ? rec_close : rec_assign;
      push.rec1  = close_first ? rec_assign : rec_final;
      push.rec2  = rec_final;
   end

   // open-group state
   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff    <= 1'b0;
         start_ff   <= '0;
         end_ff     <= '0;
         poll_ff    <= '0;
         counter_ff <= '0;
      end else if (load) begin
         open_ff    <= !in_ff.final_tag;
         start_ff   <= start_in;
         end_ff     <= end_in;
         poll_ff    <= poll_in;
         counter_ff <= counter_in;
      end
   end

   `TSG_ASSERT_NEXT(a_final_closes, clock, reset, load && in_ff.final_tag, !open_ff, "final tag left group open")
   `TSG_ASSERT_NEXT(a_tag_opens, clock, reset, load && !in_ff.final_tag, open_ff, "group not open after tag")
   `TSG_ASSERT_SAME(a_open_poll_set, clock, reset, open_ff, poll_ff != '0, "open group has zero poll period")

endmodule

@@ sv/tsg_rsp_buf.sv @@
// ----------------------------------------------------------------------------
// tsg_rsp_buf
// Three-slot result buffer; drains one record per cycle while rsp_ready is
// high and works out the span length and register fields of the head record.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tsg_rsp_buf (
   input  logic              clock,
   input  logic              reset,
   input  tsg_pkg::push_type push,
   input  tsg_pkg::cfg_type  cfg,
   output logic              buf_room,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tsg_pkg::rsp_type  rsp_data
);
   import tsg_pkg::*;

   raw_rec_type       slot_ff [3];
   logic [1:0]        cnt_ff;
   logic              pop;

   raw_rec_type       head;
   logic [2:0]        w;
   logic [ADDR_W-1:0] first_reg;
   logic [ADDR_W-1:0] last_reg;

   assign rsp_valid = cnt_ff != 2'd0;
   assign pop       = rsp_valid && rsp_ready;
   assign buf_room  = (cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && rsp_ready);

   // occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else if (push.valid) begin
         cnt_ff <= push.count;
      end else if (pop) begin
         cnt_ff <= cnt_ff - 2'd1;
      end
   end

   // slot load and shift toward the head
   always_ff @(posedge clock) begin
      if (push.valid) begin
         slot_ff[0] <= push.rec0;
         slot_ff[1] <= push.rec1;
         slot_ff[2] <= push.rec2;
      end else if (pop) begin
         slot_ff[0] <= slot_ff[1];
         slot_ff[1] <= slot_ff[2];
      end
   end

   // derived fields of the head record
   assign head      = slot_ff[0];
   assign w         = (cfg.register_width_log2 > MAX_REG_W_LOG2) ?
                      MAX_REG_W_LOG2 : cfg.register_width_log2;
   assign first_reg = head.start_bit >> w;
   assign last_reg  = head.end_bit >> w;

   always_comb begin
      rsp_data.record_kind       = head.kind;
      rsp_data.group_number      = head.number;
      rsp_data.span_start_bit    = head.start_bit;
      rsp_data.span_end_bit      = head.end_bit;
      rsp_data.span_length_bits  = (head.end_bit >= head.start_bit) ?
         ({1'b0, head.end_bit - head.start_bit} + 21'd1) : '0;
      rsp_data.group_poll_period = head.poll;
      rsp_data.first_register    = first_reg;
      rsp_data.register_count    = (last_reg >= first_reg) ?
         ({1'b0, last_reg - first_reg} + 21'd1) : '0;
      rsp_data.last_record       = head.last;
   end

   `TSG_ASSERT_SAME(a_push_room, clock, reset, push.valid, (cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && pop), "push into busy buffer")
   `TSG_ASSERT_NEXT(a_drain_step, clock, reset, pop && !push.valid, cnt_ff == $past(cnt_ff) - 2'd1, "occupancy did not drop")
   `TSG_ASSERT_SAME(a_push_count, clock, reset, push.valid, push.count != 2'd0, "push of zero records")

endmodule

@@ sv/tag_span_grouper.sv @@
// ----------------------------------------------------------------------------
// tag_span_grouper
// Merges start-ordered tags into read groups and reports each tag's group
// and every closed group with its register range.
// ----------------------------------------------------------------------------
// Each tag gives one assignment record, preceded by a group record when it
// closes the open group and followed by a group record when it is marked
// final, so one tag yields one to three records. The result buffer hands
// out one record per cycle while rsp_ready is high; tags yielding one record
// stream back to back, while a tag yielding two or three records holds the
// next tag in the input register until the buffer hands out the last of
// them. While records wait in the buffer one more tag is taken into the
// input register, after which the input stalls until the buffer can take
// that tag's records. The first record of a tag passes through the input
// register and then a buffer slot before it is valid. Configuration writes
// are registered and should be made only while no records are outstanding.
// ----------------------------------------------------------------------------
module tag_span_grouper (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  tsg_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output tsg_pkg::rsp_type               rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [tsg_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tsg_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import tsg_pkg::*;

   cfg_type  cfg;
   push_type push;
   logic     buf_room;

   // configuration registers
   tsg_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // group merge
   tsg_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .cfg       (cfg),
      .buf_room  (buf_room),
      .push      (push)
   );

   // result buffer
   tsg_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .cfg       (cfg),
      .buf_room  (buf_room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
